// ----- rtl/bbes_pkg.sv -----
// ============================================================================
// bbes_pkg
// Shared widths, reset values, codes and the command and status structures
// of the buzzer beep envelope sequencer.
// ============================================================================
package bbes_pkg;

   localparam int unsigned DUTY_W     = 9;
   localparam int unsigned COUNT_W    = 8;
   localparam int unsigned DUR_W      = 16;
   localparam int unsigned LEVEL_W    = 16;
   localparam int unsigned WRAP_W     = 16;
   localparam int unsigned GAP_W      = 16;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 16;

   // Duty is in 1/256 units.
   localparam int unsigned Q8_SHIFT = 8;

   localparam int unsigned RAMP_STEPS_DEF = 100;

   localparam logic [WRAP_W-1:0] WRAP_RESET = 16'd7812;
   localparam logic [GAP_W-1:0]  GAP_RESET  = 16'd100;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_TOP = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_MS   = 1'b1;

   // Request operations.
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef struct packed {
      logic latch_start;
      logic finish;
      logic dwell_dec;
      logic dwell_dur;
      logic dwell_gap;
      logic dwell_ramp;
      logic rep_dec;
      logic step_clr;
      logic step_inc;
      logic step_dec;
      logic calc_start;
      logic calc_ramp;
      logic level_zero;
      logic level_calc;
   } cmd_type;

   typedef struct packed {
      logic req_steady;
      logic dur_zero;
      logic gap_zero;
      logic dwell_zero;
      logic rep_gt1;
      logic step_below_top;
      logic step_nonzero;
      logic mode_ramp;
      logic mode_end;
      logic mode_peak;
      logic calc_done;
   } status_type;

endpackage

// ----- rtl/bbes_datapath.sv -----
// ============================================================================
// bbes_datapath
// Latched start settings, step, dwell and repeat counters, configuration
// registers and the three-stage level arithmetic.
// ============================================================================
module bbes_datapath #(
   parameter int unsigned RAMP_STEPS = bbes_pkg::RAMP_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bbes_pkg::cmd_type                 cmd,
   output bbes_pkg::status_type              status,
   input  logic [bbes_pkg::DUTY_W-1:0]       req_duty_q8,
   input  logic [bbes_pkg::COUNT_W-1:0]      req_repeat_count,
   input  logic [bbes_pkg::DUR_W-1:0]        req_duration_ms,
   input  logic                              req_ramp_mode,
   input  logic                              req_end_mode,
   input  logic                              req_end_at_peak,
   input  logic                              csr_we,
   input  logic [bbes_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bbes_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic [bbes_pkg::LEVEL_W-1:0]      level
);
   import bbes_pkg::*;

   localparam int unsigned STEP_W = $clog2(RAMP_STEPS + 1);
   localparam int unsigned OP_W   = DUTY_W + STEP_W;
   localparam int unsigned PROD_W = OP_W + WRAP_W;
   localparam int unsigned Y_W    = PROD_W - Q8_SHIFT;
   localparam int unsigned K_LVL  = Y_W + STEP_W;
   localparam int unsigned LP_W   = Y_W + K_LVL + 1;
   localparam int unsigned HD_W   = DUR_W - 1;
   localparam int unsigned K_DW   = HD_W + STEP_W;
   localparam int unsigned DP_W   = HD_W + K_DW + 1;

   // Reciprocals rounded up; with the shift chosen this way the quotient is
   // exact for every dividend of the given width.
   localparam logic [K_LVL:0] RECIP_LVL =
      (K_LVL + 1)'(((64'd1 << K_LVL) + 64'(RAMP_STEPS) - 64'd1) / 64'(RAMP_STEPS));
   localparam logic [K_DW:0]  RECIP_DW  =
      (K_DW + 1)'(((64'd1 << K_DW) + 64'(RAMP_STEPS) - 64'd1) / 64'(RAMP_STEPS));
   localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(RAMP_STEPS);

   localparam int unsigned M_RAMP = 0;
   localparam int unsigned M_END  = 1;
   localparam int unsigned M_PEAK = 2;

   logic [DUTY_W-1:0]  duty_ff,  duty_in;
   logic [DUR_W-1:0]   dur_ff,   dur_in;
   logic [2:0]         mode_ff,  mode_in;
   logic [STEP_W-1:0]  step_ff,  step_in;
   logic [DUR_W-1:0]   dwell_ff, dwell_in;
   logic [COUNT_W-1:0] rep_ff,   rep_in;
   logic [DUR_W-1:0]   rdw_ff,   rdw_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [WRAP_W-1:0]  wrap_ff,  wrap_in;
   logic [GAP_W-1:0]   gap_ff,   gap_in;
   logic [2:0]         vld_ff,   vld_in;
   logic [2:0]         ramp_ff,  ramp_in;
   logic [OP_W-1:0]    op_ff,    op_in;
   logic [PROD_W-1:0]  prod_ff,  prod_in;
   logic [Y_W-1:0]     y3_ff,    y3_in;
   logic [Y_W-1:0]     q3_ff,    q3_in;

   logic [HD_W-1:0]    half_dur;
   logic [DP_W-1:0]    dw_prod;
   logic [HD_W-1:0]    dw_q;
   logic [LP_W-1:0]    lvl_prod;
   logic [Y_W-1:0]     sel;
   logic [LEVEL_W-1:0] sat;

   // Ramp dwell is floor(duration / (2 * steps)), at least one tick.
   always_comb begin
      half_dur = req_duration_ms[DUR_W-1:1];
      dw_prod  = DP_W'(half_dur) * DP_W'(RECIP_DW);
      dw_q     = dw_prod[K_DW +: HD_W];
   end

   always_comb begin
      op_in    = cmd.calc_ramp ? OP_W'(duty_ff) * OP_W'(step_ff) : OP_W'(duty_ff);
      prod_in  = PROD_W'(op_ff) * PROD_W'(wrap_ff);
      y3_in    = prod_ff[PROD_W-1:Q8_SHIFT];
      lvl_prod = LP_W'(y3_in) * LP_W'(RECIP_LVL);
      q3_in    = lvl_prod[K_LVL +: Y_W];
      sel      = ramp_ff[2] ? q3_ff : y3_ff;
      sat      = (|sel[Y_W-1:LEVEL_W]) ? {LEVEL_W{1'b1}} : sel[LEVEL_W-1:0];
      vld_in   = {vld_ff[1:0], cmd.calc_start};
      ramp_in  = {ramp_ff[1:0], cmd.calc_ramp};
   end

   always_comb begin
      duty_in  = duty_ff;
      dur_in   = dur_ff;
      mode_in  = mode_ff;
      rdw_in   = rdw_ff;
      step_in  = step_ff;
      dwell_in = dwell_ff;
      rep_in   = rep_ff;
      level_in = level_ff;
      wrap_in  = wrap_ff;
      gap_in   = gap_ff;

      if (cmd.latch_start) begin
         duty_in = req_duty_q8;
         dur_in  = req_duration_ms;
         mode_in = {req_end_at_peak, req_end_mode, req_ramp_mode};
         rdw_in  = (dw_q == '0) ? DUR_W'(1) : {1'b0, dw_q};
      end

      priority if (cmd.latch_start || cmd.step_clr) begin
         step_in = '0;
      end else if (cmd.step_inc) begin
         step_in = step_ff + STEP_W'(1);
      end else if (cmd.step_dec) begin
         step_in = step_ff - STEP_W'(1);
      end

      priority if (cmd.finish) begin
         dwell_in = '0;
      end else if (cmd.dwell_dur) begin
         dwell_in = dur_ff;
      end else if (cmd.dwell_gap) begin
         dwell_in = gap_ff;
      end else if (cmd.dwell_ramp) begin
         dwell_in = rdw_ff;
      end else if (cmd.dwell_dec) begin
         dwell_in = dwell_ff - DUR_W'(1);
      end

      priority if (cmd.finish) begin
         rep_in = '0;
      end else if (cmd.latch_start) begin
         rep_in = (req_repeat_count == '0) ? COUNT_W'(1) : req_repeat_count;
      end else if (cmd.rep_dec) begin
         rep_in = rep_ff - COUNT_W'(1);
      end

      priority if (cmd.level_zero) begin
         level_in = '0;
      end else if (cmd.level_calc) begin
         level_in = sat;
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_WRAP_TOP: wrap_in = csr_wdata;
            CSR_GAP_MS:   gap_in  = csr_wdata;
            default:      wrap_in = wrap_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff  <= '0;
         dur_ff   <= '0;
         mode_ff  <= '0;
         rdw_ff   <= '0;
         step_ff  <= '0;
         dwell_ff <= '0;
         rep_ff   <= '0;
         level_ff <= '0;
         wrap_ff  <= WRAP_RESET;
         gap_ff   <= GAP_RESET;
         vld_ff   <= '0;
      end else begin
         duty_ff  <= duty_in;
         dur_ff   <= dur_in;
         mode_ff  <= mode_in;
         rdw_ff   <= rdw_in;
         step_ff  <= step_in;
         dwell_ff <= dwell_in;
         rep_ff   <= rep_in;
         level_ff <= level_in;
         wrap_ff  <= wrap_in;
         gap_ff   <= gap_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ramp_ff <= ramp_in;
      op_ff   <= op_in;
      prod_ff <= prod_in;
      y3_ff   <= y3_in;
      q3_ff   <= q3_in;
   end

   always_comb begin
      status.req_steady     = (req_repeat_count == '0) && !req_ramp_mode;
      status.dur_zero       = (dur_ff == '0);
      status.gap_zero       = (gap_ff == '0);
      status.dwell_zero     = (dwell_ff == '0);
      status.rep_gt1        = (rep_ff > COUNT_W'(1));
      status.step_below_top = (step_ff < STEP_TOP);
      status.step_nonzero   = (step_ff != '0);
      status.mode_ramp      = mode_ff[M_RAMP];
      status.mode_end       = mode_ff[M_END];
      status.mode_peak      = mode_ff[M_PEAK];
      status.calc_done      = vld_ff[2];
   end

   assign level = level_ff;

endmodule

// ----- rtl/bbes_ctrl.sv -----
// ============================================================================
// bbes_ctrl
// Sequence phase register and the control state machine that walks through
// phase entries, zero-length fall-through and level computation per request.
// ============================================================================
module bbes_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  bbes_pkg::status_type status,
   output bbes_pkg::cmd_type    cmd,
   input  logic                 rsp_free,
   output logic                 rsp_load,
   output logic                 busy
);
   import bbes_pkg::*;

   typedef enum logic [9:0] {
      C_IDLE   = 10'b0000000001,
      C_STEADY = 10'b0000000010,
      C_START  = 10'b0000000100,
      C_HOLD   = 10'b0000001000,
      C_GAP    = 10'b0000010000,
      C_NEXT   = 10'b0000100000,
      C_RAMP   = 10'b0001000000,
      C_CALC   = 10'b0010000000,
      C_TICK   = 10'b0100000000,
      C_RESP   = 10'b1000000000
   } ctl_type;

   typedef enum logic [5:0] {
      P_IDLE = 6'b000001,
      P_HOLD = 6'b000010,
      P_GAP  = 6'b000100,
      P_UP   = 6'b001000,
      P_DOWN = 6'b010000,
      P_REUP = 6'b100000
   } phase_type;

   ctl_type   state_ff, state_in;
   phase_type phase_ff, phase_in;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_load  = 1'b0;

      unique case (state_ff)
         C_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == OP_START) begin
                  if (phase_ff == P_IDLE) begin
                     cmd.latch_start = 1'b1;
                     if (status.req_steady) begin
                        cmd.finish = 1'b1;
                        state_in   = C_STEADY;
                     end else begin
                        state_in = C_START;
                     end
                  end else begin
                     // A start request while a sequence runs changes nothing.
                     state_in = C_RESP;
                  end
               end else if (phase_ff != P_IDLE) begin
                  cmd.dwell_dec = 1'b1;
                  state_in      = C_TICK;
               end else begin
                  state_in = C_RESP;
               end
            end
         end
         C_STEADY: begin
            cmd.calc_start = 1'b1;
            state_in       = C_CALC;
         end
         C_START: begin
            if (status.mode_ramp) begin
               phase_in = P_UP;
               state_in = C_RAMP;
            end else begin
               state_in = C_HOLD;
            end
         end
         C_HOLD: begin
            phase_in = P_HOLD;
            if (!status.dur_zero) begin
               cmd.dwell_dur  = 1'b1;
               cmd.calc_start = 1'b1;
               state_in       = C_CALC;
            end else begin
               state_in = C_GAP;
            end
         end
         C_GAP: begin
            phase_in       = P_GAP;
            cmd.level_zero = 1'b1;
            if (!status.gap_zero) begin
               cmd.dwell_gap = 1'b1;
               state_in      = C_RESP;
            end else begin
               state_in = C_NEXT;
            end
         end
         C_NEXT: begin
            if (status.rep_gt1) begin
               cmd.rep_dec  = 1'b1;
               cmd.step_clr = 1'b1;
               if (status.mode_ramp) begin
                  phase_in = P_UP;
                  state_in = C_RAMP;
               end else begin
                  state_in = C_HOLD;
               end
            end else begin
               cmd.finish     = 1'b1;
               cmd.level_zero = 1'b1;
               phase_in       = P_IDLE;
               state_in       = C_RESP;
            end
         end
         C_RAMP: begin
            cmd.dwell_ramp = 1'b1;
            cmd.calc_start = 1'b1;
            cmd.calc_ramp  = 1'b1;
            state_in       = C_CALC;
         end
         C_CALC: begin
            if (status.calc_done) begin
               cmd.level_calc = 1'b1;
               state_in       = C_RESP;
            end
         end
         C_TICK: begin
            state_in = C_RESP;
            if (status.dwell_zero) begin
               unique case (phase_ff)
                  P_HOLD: state_in = C_GAP;
                  P_GAP:  state_in = C_NEXT;
                  P_UP: begin
                     if (status.step_below_top) begin
                        cmd.step_inc = 1'b1;
                     end else begin
                        phase_in = P_DOWN;
                     end
                     state_in = C_RAMP;
                  end
                  P_DOWN: begin
                     if (status.step_nonzero) begin
                        cmd.step_dec = 1'b1;
                        state_in     = C_RAMP;
                     end else if (status.mode_end && status.mode_peak) begin
                        cmd.step_clr = 1'b1;
                        phase_in     = P_REUP;
                        state_in     = C_RAMP;
                     end else if (status.mode_end) begin
                        cmd.finish     = 1'b1;
                        cmd.level_zero = 1'b1;
                        phase_in       = P_IDLE;
                     end else begin
                        state_in = C_GAP;
                     end
                  end
                  P_REUP: begin
                     if (status.step_below_top) begin
                        cmd.step_inc = 1'b1;
                        state_in     = C_RAMP;
                     end else begin
                        // The peak level stays after the sequence ends.
                        cmd.finish = 1'b1;
                        phase_in   = P_IDLE;
                     end
                  end
                  default: begin
                     cmd.finish     = 1'b1;
                     cmd.level_zero = 1'b1;
                     phase_in       = P_IDLE;
                  end
               endcase
            end
         end
         C_RESP: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         phase_ff <= P_IDLE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign busy = (phase_ff != P_IDLE);

endmodule

// ----- rtl/buzzer_beep_envelope_sequencer.sv -----
// Path from accepted request to response: an idle tick or an ignored start goes
// straight to the response state, a tick that ends no phase passes C_TICK, one
// that opens a gap also C_GAP, and a steady, hold or ramp level goes through the
// three-stage multiply; each phase passed on the way adds a state to the path.
// Throughput: one request at a time, the next is taken once the response is held.
// Synchronous active-high reset: idle phase, level 0, wrap_top 7812, gap_ms 100.
// ============================================================================
// buzzer_beep_envelope_sequencer
// Top level: controller, datapath and the registered response stage of a
// buzzer PWM level sequencer driven by millisecond ticks and start requests.
// ============================================================================
module buzzer_beep_envelope_sequencer #(
   parameter int unsigned RAMP_STEPS = bbes_pkg::RAMP_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic [bbes_pkg::DUTY_W-1:0]       req_duty_q8,
   input  logic [bbes_pkg::COUNT_W-1:0]      req_repeat_count,
   input  logic [bbes_pkg::DUR_W-1:0]        req_duration_ms,
   input  logic                              req_ramp_mode,
   input  logic                              req_end_mode,
   input  logic                              req_end_at_peak,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bbes_pkg::LEVEL_W-1:0]      rsp_pwm_level,
   output logic                              rsp_busy_res,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bbes_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bbes_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bbes_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic               rsp_free;
   logic               rsp_load;
   logic               busy;
   logic [LEVEL_W-1:0] level;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic               rsp_busy_ff,  rsp_busy_in;

   assign csr_ready = 1'b1;

   bbes_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .rsp_free      (rsp_free),
      .rsp_load      (rsp_load),
      .busy          (busy)
   );

   bbes_datapath #(
      .RAMP_STEPS (RAMP_STEPS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_duty_q8      (req_duty_q8),
      .req_repeat_count (req_repeat_count),
      .req_duration_ms  (req_duration_ms),
      .req_ramp_mode    (req_ramp_mode),
      .req_end_mode     (req_end_mode),
      .req_end_at_peak  (req_end_at_peak),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .level            (level)
   );

   // The response register frees up in the same cycle as it is taken.
   always_comb begin
      rsp_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_level_in = rsp_load ? level : rsp_level_ff;
      rsp_busy_in  = rsp_load ? busy  : rsp_busy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_level_ff <= rsp_level_in;
      rsp_busy_ff  <= rsp_busy_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pwm_level = rsp_level_ff;
   assign rsp_busy_res  = rsp_busy_ff;

endmodule
